FILE: hw/rtl/greedy_load_rebalancer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the greedy load rebalancer
// Implication forms shared by the checker.
// ---------------------------------------------------------------------------
`ifndef GREEDY_LOAD_REBALANCER_MACROS_SVH
`define GREEDY_LOAD_REBALANCER_MACROS_SVH

// same-cycle implication
`define GLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/glr_pkg.sv
// ---------------------------------------------------------------------------
// glr_pkg
// Types, constants and helpers of the greedy load rebalancer.
// ---------------------------------------------------------------------------
package glr_pkg;

  localparam int MaxTasksDef = 16;
  localparam int MaxProcDef  = 8;

  localparam int RunTimeW = 64;
  localparam int UtilW    = 16;
  localparam int LoadW    = 20;
  localparam int ProcW    = 3;
  localparam int IdW      = 4;
  localparam int DivW     = 32;
  localparam int CfgW     = 8;
  localparam int CfgIdxW  = 2;

  localparam logic [DivW-1:0]  NsPerPctSec = 32'd10000000;
  localparam logic [LoadW-1:0] LoadMax     = '1;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_ACTIVE   = 2'd1,
    CFG_THRESH   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [RunTimeW-1:0] run_time;
    logic [ProcW-1:0]    current_processor;
    logic [IdW-1:0]      task_id;
    logic                last_task;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]   out_task_id;
    logic [ProcW-1:0] new_processor;
    logic             moved;
    logic             rebalanced;
    logic             last_result;
  } out_item_t;

  // saturating load arithmetic
  function automatic logic [LoadW-1:0] load_add(input logic [LoadW-1:0] a,
                                                input logic [UtilW-1:0] b);
    logic [LoadW:0] s;
    s = {1'b0, a} + {{(LoadW+1-UtilW){1'b0}}, b};
    return s[LoadW] ? LoadMax : s[LoadW-1:0];
  endfunction

  function automatic logic [LoadW-1:0] load_sub(input logic [LoadW-1:0] a,
                                                input logic [UtilW-1:0] b);
    logic [LoadW-1:0] bx;
    bx = {{(LoadW-UtilW){1'b0}}, b};
    return (a >= bx) ? (a - bx) : '0;
  endfunction

endpackage

FILE: hw/rtl/greedy_load_rebalancer.sv
// ---------------------------------------------------------------------------
// greedy_load_rebalancer
// Per-round task load accounting with greedy largest-first reassignment.
// ---------------------------------------------------------------------------
//  channel  ports                          transfer
//  input    start, busy, in_data           start && !busy
//  result   out_valid, out_data            out_valid, one cycle each
//  config   cfg_we, cfg_idx, cfg_wdata     cfg_we
//
//  An item passes through lookup, divider start, a 16-step serial divide
//  and update. The last item of a round then adds sum, average and deviation
//  passes, then one pass to list the results, or one pass per task to
//  reassign, each pass one scan of the task RAM read port.
//  Reset is synchronous; no clearing pass is needed. Results are not stalled.
// ---------------------------------------------------------------------------
module greedy_load_rebalancer #(
  parameter int MAX_TASKS      = glr_pkg::MaxTasksDef,
  parameter int MAX_PROCESSORS = glr_pkg::MaxProcDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [glr_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [glr_pkg::CfgW-1:0]    cfg_wdata,
  input  logic                        start,
  input  glr_pkg::in_item_t           in_data,
  output logic                        busy,
  output logic                        out_valid,
  output glr_pkg::out_item_t          out_data
);
  import glr_pkg::*;

  localparam int TW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int PW   = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
  localparam int NW   = $clog2(MAX_PROCESSORS + 1);
  localparam int TotW = LoadW + PW;
  localparam int ACW  = $clog2(TotW + 1);
  localparam int UW   = UtilW + ProcW;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LOOKUP = 11'b00000000010,
    S_DIVGO  = 11'b00000000100,
    S_DIVIDE = 11'b00000001000,
    S_UPDATE = 11'b00000010000,
    S_SUM    = 11'b00000100000,
    S_AVG    = 11'b00001000000,
    S_DEV    = 11'b00010000000,
    S_SCAN   = 11'b00100000000,
    S_PICK   = 11'b01000000000,
    S_ASSIGN = 11'b10000000000
  } state_t;

  state_t state_r;

  // configuration
  logic [7:0] ival_r;
  logic [3:0] nact_r;
  logic [6:0] thr_r;

  // current item
  in_item_t            item_r;
  logic [TW-1:0]       idx_r;
  logic [DivW-1:0]     div_r;
  logic [RunTimeW-1:0] delta_r;

  // per-task flags
  logic [MAX_TASKS-1:0] vld_r;
  logic [MAX_TASKS-1:0] prt_vld_r;
  logic [MAX_TASKS-1:0] done_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        pass_r;

  // processor loads: round accounting and assignment
  logic [LoadW-1:0] load_r [MAX_PROCESSORS];
  logic [LoadW-1:0] asg_r  [MAX_PROCESSORS];

  // balance check
  logic [NW-1:0]   j_r;
  logic [TotW-1:0] total_r;
  logic [NW-1:0]   arem_r;
  logic [ACW-1:0]  acnt_r;
  logic            imb_r;
  logic            rb_r;

  // scan pipeline and best pick
  logic [TW-1:0]    sc_r;
  logic             p_v_r;
  logic [TW-1:0]    p_idx_r;
  logic             best_v_r;
  logic [TW-1:0]    best_idx_r;
  logic [UtilW-1:0] best_util_r;
  logic [ProcW-1:0] best_proc_r;

  logic      out_valid_r;
  out_item_t out_r;

  // memories
  logic [TW-1:0]       raddr;
  logic [RunTimeW-1:0] prt_q;
  logic [UW-1:0]       uq;
  logic                prt_we;
  logic                util_we;
  logic [UtilW-1:0]    util_q;
  logic [ProcW-1:0]    proc_q;

  // divider
  logic             ud_go;
  logic             ud_done;
  logic [UtilW-1:0] ud_q;

  // misc
  logic [NW-1:0]    nproc;
  logic [7:0]       ival_eff;
  logic             id_ok;
  logic             oldp_ok;
  logic             curp_ok;
  logic [TW-1:0]    last_idx;
  logic [PW-1:0]    pmin;
  logic [NW:0]      atrial;
  logic             age;
  logic [NW-1:0]    arem_nxt;
  logic [TotW-1:0]  ld_ext;
  logic [TotW-1:0]  dev;
  logic             imb_now;
  logic             last_asg;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign raddr   = (state_r == S_IDLE) ? TW'(in_data.task_id) : sc_r;
  assign prt_we  = (state_r == S_LOOKUP);
  assign util_we = (state_r == S_UPDATE);
  assign ud_go   = (state_r == S_DIVGO);
  assign util_q  = uq[UW-1:ProcW];
  assign proc_q  = uq[ProcW-1:0];

  glr_ram #(.WIDTH(RunTimeW), .DEPTH(MAX_TASKS)) u_prt_ram (
    .clk   (clk),
    .we    (prt_we),
    .waddr (idx_r),
    .wdata (item_r.run_time),
    .raddr (raddr),
    .rdata (prt_q)
  );

  glr_ram #(.WIDTH(UW), .DEPTH(MAX_TASKS)) u_util_ram (
    .clk   (clk),
    .we    (util_we),
    .waddr (idx_r),
    .wdata ({ud_q, item_r.current_processor}),
    .raddr (raddr),
    .rdata (uq)
  );

  glr_udiv u_udiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (ud_go),
    .dividend (delta_r),
    .divisor  (div_r),
    .done     (ud_done),
    .quotient (ud_q)
  );

  // clamps and range checks
  always_comb begin
    ival_eff = (ival_r == 8'd0) ? 8'd1 : ival_r;
    if (nact_r == 4'd0) begin
      nproc = NW'(1);
    end else if (int'(nact_r) > MAX_PROCESSORS) begin
      nproc = NW'(MAX_PROCESSORS);
    end else begin
      nproc = NW'(nact_r);
    end
    id_ok   = int'(in_data.task_id) < MAX_TASKS;
    oldp_ok = int'(proc_q) < MAX_PROCESSORS;
    curp_ok = int'(item_r.current_processor) < MAX_PROCESSORS;
  end

  // highest valid task marks the final listed result
  always_comb begin
    last_idx = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (vld_r[i]) last_idx = TW'(i);
    end
  end

  // least-loaded active processor, lowest index on ties
  always_comb begin
    pmin = '0;
    for (int j = 1; j < MAX_PROCESSORS; j++) begin
      if (NW'(j) < nproc && asg_r[j] < asg_r[pmin]) pmin = PW'(j);
    end
  end

  // average: one restoring step per cycle
  always_comb begin
    atrial   = {arem_r, total_r[TotW-1]};
    age      = atrial >= {1'b0, nproc};
    arem_nxt = age ? NW'(atrial - {1'b0, nproc}) : atrial[NW-1:0];
  end

  // deviation of one processor from the average
  always_comb begin
    ld_ext  = TotW'(load_r[j_r[PW-1:0]]);
    dev     = (ld_ext > total_r) ? (ld_ext - total_r) : (total_r - ld_ext);
    imb_now = imb_r | (dev > TotW'(thr_r));
    last_asg = (pass_r + 1'b1) == cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ival_r      <= 8'd1;
      nact_r      <= 4'd8;
      thr_r       <= 7'd5;
      vld_r       <= '0;
      prt_vld_r   <= '0;
      done_r      <= '0;
      cnt_r       <= '0;
      load_r      <= '{default: '0};
      out_valid_r <= 1'b0;
      p_v_r       <= 1'b0;
      best_v_r    <= 1'b0;
      imb_r       <= 1'b0;
      rb_r        <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      p_v_r       <= 1'b0;

      // register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_INTERVAL: ival_r <= cfg_wdata;
          CFG_ACTIVE:   nact_r <= cfg_wdata[3:0];
          CFG_THRESH:   thr_r  <= cfg_wdata[6:0];
          default:      ;
        endcase
      end

      // scan data returns from the task RAM
      if (p_v_r) begin
        if (rb_r) begin
          if (!best_v_r || util_q > best_util_r) begin
            best_v_r    <= 1'b1;
            best_idx_r  <= p_idx_r;
            best_util_r <= util_q;
            best_proc_r <= proc_q;
          end
        end else begin
          out_valid_r <= 1'b1;
          out_r       <= '{out_task_id:   IdW'(p_idx_r),
                           new_processor: proc_q,
                           moved:         1'b0,
                           rebalanced:    1'b0,
                           last_result:   p_idx_r == last_idx};
        end
      end

      case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r <= in_data;
            idx_r  <= TW'(in_data.task_id);
            div_r  <= {{(DivW-8){1'b0}}, ival_eff} * NsPerPctSec;
            if (id_ok) begin
              state_r <= S_LOOKUP;
            end else if (in_data.last_task) begin
              j_r     <= '0;
              total_r <= '0;
              state_r <= S_SUM;
            end
          end
        end
        // delta since last round; back out the earlier entry of this round
        S_LOOKUP: begin
          delta_r          <= item_r.run_time - (prt_vld_r[idx_r] ? prt_q : '0);
          prt_vld_r[idx_r] <= 1'b1;
          if (vld_r[idx_r] && oldp_ok) begin
            load_r[PW'(proc_q)] <= load_sub(load_r[PW'(proc_q)], util_q);
          end
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          state_r <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (ud_done) state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          if (curp_ok) begin
            load_r[PW'(item_r.current_processor)] <=
              load_add(load_r[PW'(item_r.current_processor)], ud_q);
          end
          vld_r[idx_r] <= 1'b1;
          if (!vld_r[idx_r]) cnt_r <= cnt_r + 1'b1;
          if (item_r.last_task) begin
            j_r     <= '0;
            total_r <= '0;
            state_r <= S_SUM;
          end else begin
            state_r <= S_IDLE;
          end
        end
        // total of active loads
        S_SUM: begin
          total_r <= total_r + TotW'(load_r[j_r[PW-1:0]]);
          if (j_r == nproc - 1'b1) begin
            arem_r  <= '0;
            acnt_r  <= '0;
            state_r <= S_AVG;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        // total_r shifts into the quotient
        S_AVG: begin
          arem_r  <= arem_nxt;
          total_r <= {total_r[TotW-2:0], age};
          acnt_r  <= acnt_r + 1'b1;
          if (acnt_r == ACW'(TotW - 1)) begin
            j_r     <= '0;
            imb_r   <= 1'b0;
            state_r <= S_DEV;
          end
        end
        S_DEV: begin
          imb_r <= imb_now;
          if (j_r == nproc - 1'b1) begin
            if (cnt_r == '0) begin
              vld_r   <= '0;
              load_r  <= '{default: '0};
              state_r <= S_IDLE;
            end else begin
              rb_r     <= imb_now;
              sc_r     <= '0;
              best_v_r <= 1'b0;
              pass_r   <= '0;
              done_r   <= '0;
              asg_r    <= '{default: '0};
              state_r  <= S_SCAN;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        // one read per cycle through the task RAM
        S_SCAN: begin
          p_v_r   <= vld_r[sc_r] && (!rb_r || !done_r[sc_r]);
          p_idx_r <= sc_r;
          if (sc_r == TW'(MAX_TASKS - 1)) begin
            state_r <= S_PICK;
          end else begin
            sc_r <= sc_r + 1'b1;
          end
        end
        S_PICK: begin
          if (rb_r) begin
            state_r <= S_ASSIGN;
          end else begin
            vld_r   <= '0;
            load_r  <= '{default: '0};
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        // place the largest remaining task
        S_ASSIGN: begin
          asg_r[pmin]        <= load_add(asg_r[pmin], best_util_r);
          done_r[best_idx_r] <= 1'b1;
          pass_r             <= pass_r + 1'b1;
          out_valid_r        <= 1'b1;
          out_r              <= '{out_task_id:   IdW'(best_idx_r),
                                  new_processor: ProcW'(pmin),
                                  moved:         ProcW'(pmin) != best_proc_r,
                                  rebalanced:    1'b1,
                                  last_result:   last_asg};
          if (last_asg) begin
            vld_r   <= '0;
            load_r  <= '{default: '0};
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            sc_r     <= '0;
            best_v_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/glr_ram.sv
// ---------------------------------------------------------------------------
// glr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module glr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/glr_udiv.sv
// ---------------------------------------------------------------------------
// glr_udiv
// Bit-serial utilization divider: 64-bit delta over 32-bit divisor,
// quotient saturated to 16 bits, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module glr_udiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [glr_pkg::RunTimeW-1:0] dividend,
  input  logic [glr_pkg::DivW-1:0]     divisor,
  output logic                         done,
  output logic [glr_pkg::UtilW-1:0]    quotient
);
  import glr_pkg::*;

  localparam int CntW = $clog2(UtilW);

  logic            run_r;
  logic            done_r;
  logic [CntW-1:0] cnt_r;
  logic [DivW-1:0] rem_r;
  logic [UtilW-1:0] lo_r;
  logic [UtilW-1:0] q_r;
  logic            sat_r;

  logic [DivW:0]   trial;
  logic            ge;
  logic [DivW-1:0] rem_nxt;

  // one restoring step
  always_comb begin
    trial   = {rem_r, lo_r[UtilW-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? DivW'(trial - {1'b0, divisor}) : trial[DivW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        // quotient overflows 16 bits when delta >> 16 reaches the divisor
        sat_r <= dividend[RunTimeW-1:UtilW] >= {{(RunTimeW-UtilW-DivW){1'b0}}, divisor};
        rem_r <= dividend[UtilW+DivW-1:UtilW];
        lo_r  <= dividend[UtilW-1:0];
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        lo_r  <= {lo_r[UtilW-2:0], 1'b0};
        q_r   <= {q_r[UtilW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(UtilW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = sat_r ? '1 : q_r;

endmodule

FILE: hw/rtl/glr_checker.sv
// ---------------------------------------------------------------------------
// glr_checker
// Port-level checks of the greedy load rebalancer, bound to the top level.
// ---------------------------------------------------------------------------
`include "greedy_load_rebalancer_macros.svh"

module glr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input glr_pkg::out_item_t out_data
);
  import glr_pkg::*;

  // only the final result of a round may show after the block went idle
  `GLR_ASSERT_IMP(a_res_busy, clk, rst_n, out_valid && !out_data.last_result, busy, "result outside round")

  // a round ends with its final result; the next round needs new items
  `GLR_ASSERT_NXT(a_last_gap, clk, rst_n, out_valid && out_data.last_result, !out_valid, "result after final")

  // a task can only move when a rebalance took place
  `GLR_ASSERT_IMP(a_move_rb, clk, rst_n, out_valid && !out_data.rebalanced, !out_data.moved, "move w/o rebalance")

  // work only begins with a start transaction
  `GLR_ASSERT_IMP(a_busy_rise, clk, rst_n, $rose(busy), $past(start), "busy without start")

endmodule

bind greedy_load_rebalancer glr_checker u_glr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
